### rtl/cdf_pkg.sv
// Shared field widths and parameter defaults for the CAN receive duplicate filter.
// No dependencies; imported by cdf_frame_cmp, the top level and the simulation files.
`default_nettype none

package cdf_pkg;

  localparam int CHANNELS_DEF       = 4;
  localparam int MAX_DATA_BYTES_DEF = 64;
  localparam int OUT_DATA_BYTES_DEF = 64;

  localparam int CH_FIELD_W = 3;
  localparam int ID_W       = 32;
  localparam int PARAMS_W   = 16;
  localparam int TS_W       = 32;
  localparam int DLEN_W     = 7;
  localparam int WORD_W     = 64;
  localparam int DATA_WORDS = 8;
  localparam int DATA_BYTES = DATA_WORDS * WORD_W / 8;
  localparam int DATA_W     = DATA_WORDS * WORD_W;

  // ext, rtr, fd, brs and the raw length byte; bits 7:4 are dropped
  localparam logic [PARAMS_W-1:0] PARAMS_KEEP = 16'hFF0F;
  localparam int                  RAW_LEN_LSB = 8;

endpackage

`default_nettype wire

### rtl/cdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/cdf_frame_cmp.sv
// Length clamp, byte masking and snapshot compare for one frame.
// Depends on cdf_pkg.
`default_nettype none

module cdf_frame_cmp
  import cdf_pkg::*;
#(
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
  parameter int OUT_DATA_BYTES = OUT_DATA_BYTES_DEF,
  localparam int LEN_W  = $clog2(MAX_DATA_BYTES + 1),
  localparam int SNAP_W = ID_W + PARAMS_W + TS_W + LEN_W + MAX_DATA_BYTES * 8
) (
  input  wire logic [ID_W-1:0]     can_id,
  input  wire logic [PARAMS_W-1:0] frame_params,
  input  wire logic [TS_W-1:0]     timestamp,
  input  wire logic [DATA_W-1:0]   data,
  input  wire logic                snap_valid,
  input  wire logic [SNAP_W-1:0]   snap,
  output logic                     is_dup,
  output logic      [SNAP_W-1:0]   new_snap,
  output logic      [DLEN_W-1:0]   out_length,
  output logic      [DATA_W-1:0]   out_data
);

  logic [7:0]        raw_len;
  logic [LEN_W-1:0]  len;
  logic [DATA_W-1:0] masked;

  // ones over every byte below nbytes
  function automatic logic [DATA_W-1:0] byte_mask(input logic [DLEN_W-1:0] nbytes);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_BYTES; i++) begin
      m[i*8 +: 8] = {8{(i < int'(nbytes))}};
    end
    return m;
  endfunction

  always_comb begin
    raw_len = frame_params[RAW_LEN_LSB +: 8];
    if (int'(raw_len) > MAX_DATA_BYTES) begin
      len = LEN_W'(MAX_DATA_BYTES);
    end else begin
      len = LEN_W'(raw_len);
    end

    if (int'(len) > OUT_DATA_BYTES) begin
      out_length = DLEN_W'(OUT_DATA_BYTES);
    end else begin
      out_length = DLEN_W'(len);
    end

    masked   = data & byte_mask(DLEN_W'(len));
    out_data = masked & byte_mask(out_length);

    new_snap = {masked[MAX_DATA_BYTES*8-1:0], len, timestamp,
                frame_params & PARAMS_KEEP, can_id};
    is_dup   = snap_valid && (snap == new_snap);
  end

endmodule

`default_nettype wire

### rtl/can_rx_duplicate_frame_filter.sv
// Top level of the CAN receive duplicate-frame filter.
// Depends on cdf_pkg, cdf_ram and cdf_frame_cmp.
//
//   channel  | handshake                  | payload
//   frame    | frame_valid / frame_stall  | channel, can_id, frame_params, timestamp,
//            |                            | data_word_0..7
//   result   | result_valid/ result_stall | accepted, out_can_id, out_timestamp, out_length,
//            |                            | out_data_word_0..7
//
// One frame per cycle while the result side is not stalled. A frame is registered at
// acceptance while its channel's snapshot is read from the snapshot RAM; the frame stage
// then compares and loads the result register once that register is free or being taken. A snapshot written in
// the same cycle as the next request's read is forwarded. Reset clears valid bits,
// counters and the handshake state; the RAM needs no clearing. A stalled result holds
// the frame stage.
`default_nettype none

module can_rx_duplicate_frame_filter
  import cdf_pkg::*;
#(
  parameter int CHANNELS       = CHANNELS_DEF,
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
  parameter int OUT_DATA_BYTES = OUT_DATA_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  frame_valid,
  output logic                       frame_stall,
  input  wire logic [CH_FIELD_W-1:0] channel,
  input  wire logic [ID_W-1:0]       can_id,
  input  wire logic [PARAMS_W-1:0]   frame_params,
  input  wire logic [TS_W-1:0]       timestamp,
  input  wire logic [WORD_W-1:0]     data_word_0,
  input  wire logic [WORD_W-1:0]     data_word_1,
  input  wire logic [WORD_W-1:0]     data_word_2,
  input  wire logic [WORD_W-1:0]     data_word_3,
  input  wire logic [WORD_W-1:0]     data_word_4,
  input  wire logic [WORD_W-1:0]     data_word_5,
  input  wire logic [WORD_W-1:0]     data_word_6,
  input  wire logic [WORD_W-1:0]     data_word_7,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic                       accepted,
  output logic      [ID_W-1:0]       out_can_id,
  output logic      [TS_W-1:0]       out_timestamp,
  output logic      [DLEN_W-1:0]     out_length,
  output logic      [WORD_W-1:0]     out_data_word_0,
  output logic      [WORD_W-1:0]     out_data_word_1,
  output logic      [WORD_W-1:0]     out_data_word_2,
  output logic      [WORD_W-1:0]     out_data_word_3,
  output logic      [WORD_W-1:0]     out_data_word_4,
  output logic      [WORD_W-1:0]     out_data_word_5,
  output logic      [WORD_W-1:0]     out_data_word_6,
  output logic      [WORD_W-1:0]     out_data_word_7
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LEN_W  = $clog2(MAX_DATA_BYTES + 1);
  localparam int SNAP_W = ID_W + PARAMS_W + TS_W + LEN_W + MAX_DATA_BYTES * 8;
  localparam int LEN_LSB = ID_W + PARAMS_W + TS_W;

  // frame stage
  logic                  s1_valid;
  logic [CH_FIELD_W-1:0] s1_ch;
  logic [ID_W-1:0]       s1_id;
  logic [PARAMS_W-1:0]   s1_params;
  logic [TS_W-1:0]       s1_ts;
  logic [DATA_W-1:0]     s1_data;
  logic                  fwd_hit;
  logic [SNAP_W-1:0]     fwd_snap;

  logic [CHANNELS-1:0]   snap_valid;
  logic [31:0]           rx_frame_count [CHANNELS];
  logic [31:0]           rx_byte_count  [CHANNELS];

  logic [DATA_W-1:0]     res_data;

  logic                  frame_acc;
  logic                  res_load;
  logic                  chan_ok;
  logic                  cur_valid;
  logic                  is_dup;
  logic                  snap_we;
  logic [SNAP_W-1:0]     ram_rdata;
  logic [SNAP_W-1:0]     cur_snap;
  logic [SNAP_W-1:0]     new_snap;
  logic [DLEN_W-1:0]     cmp_length;
  logic [DATA_W-1:0]     cmp_data;
  logic [CH_W-1:0]       s1_idx;

  assign res_load    = s1_valid && (!result_valid || !result_stall);
  assign frame_stall = s1_valid && !res_load;
  assign frame_acc   = frame_valid && !frame_stall;

  assign s1_idx    = s1_ch[CH_W-1:0];
  assign chan_ok   = ({1'b0, s1_ch} < (CH_FIELD_W + 1)'(CHANNELS));
  assign cur_valid = chan_ok && snap_valid[s1_idx];
  assign cur_snap  = fwd_hit ? fwd_snap : ram_rdata;
  assign snap_we   = res_load && chan_ok && !is_dup;

  cdf_ram #(
    .WIDTH (SNAP_W),
    .DEPTH (CHANNELS)
  ) u_snap_ram (
    .clk   (clk),
    .we    (snap_we),
    .waddr (s1_idx),
    .wdata (new_snap),
    .re    (frame_acc),
    .raddr (channel[CH_W-1:0]),
    .rdata (ram_rdata)
  );

  cdf_frame_cmp #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .OUT_DATA_BYTES (OUT_DATA_BYTES)
  ) u_cmp (
    .can_id       (s1_id),
    .frame_params (s1_params),
    .timestamp    (s1_ts),
    .data         (s1_data),
    .snap_valid   (cur_valid),
    .snap         (cur_snap),
    .is_dup       (is_dup),
    .new_snap     (new_snap),
    .out_length   (cmp_length),
    .out_data     (cmp_data)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      fwd_hit      <= 1'b0;
      snap_valid   <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        rx_frame_count[c] <= '0;
        rx_byte_count[c]  <= '0;
      end
    end else begin
      if (frame_acc) begin
        s1_valid <= 1'b1;
        // RAM read of the same channel races the write below
        fwd_hit  <= snap_we && (channel == s1_ch);
      end else if (res_load) begin
        s1_valid <= 1'b0;
      end

      if (res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      if (snap_we) begin
        snap_valid[s1_idx]     <= 1'b1;
        rx_frame_count[s1_idx] <= rx_frame_count[s1_idx] + 32'd1;
        rx_byte_count[s1_idx]  <= rx_byte_count[s1_idx]
                                  + 32'(new_snap[LEN_LSB +: LEN_W]);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (frame_acc) begin
      s1_ch     <= channel;
      s1_id     <= can_id;
      s1_params <= frame_params;
      s1_ts     <= timestamp;
      s1_data   <= {data_word_7, data_word_6, data_word_5, data_word_4,
                    data_word_3, data_word_2, data_word_1, data_word_0};
    end
    if (snap_we) begin
      fwd_snap <= new_snap;
    end
    if (res_load) begin
      accepted <= chan_ok && !is_dup;
      if (chan_ok && !is_dup) begin
        out_can_id    <= s1_id;
        out_timestamp <= s1_ts;
        out_length    <= cmp_length;
        res_data      <= cmp_data;
      end else begin
        out_can_id    <= '0;
        out_timestamp <= '0;
        out_length    <= '0;
        res_data      <= '0;
      end
    end
  end

  assign out_data_word_0 = res_data[0*WORD_W +: WORD_W];
  assign out_data_word_1 = res_data[1*WORD_W +: WORD_W];
  assign out_data_word_2 = res_data[2*WORD_W +: WORD_W];
  assign out_data_word_3 = res_data[3*WORD_W +: WORD_W];
  assign out_data_word_4 = res_data[4*WORD_W +: WORD_W];
  assign out_data_word_5 = res_data[5*WORD_W +: WORD_W];
  assign out_data_word_6 = res_data[6*WORD_W +: WORD_W];
  assign out_data_word_7 = res_data[7*WORD_W +: WORD_W];

endmodule

`default_nettype wire

### sim/cdf_filter_checker.sv
// Checker for the CAN receive duplicate-frame filter: predicts each delivery and compares.
// Watches the frame and result handshakes of the block; depends on cdf_pkg only.
module cdf_filter_checker
  import cdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  frame_valid,
  input  wire logic                  frame_stall,
  input  wire logic [CH_FIELD_W-1:0] channel,
  input  wire logic [ID_W-1:0]       can_id,
  input  wire logic [PARAMS_W-1:0]   frame_params,
  input  wire logic [TS_W-1:0]       timestamp,
  input  wire logic [WORD_W-1:0]     data_word_0,
  input  wire logic [WORD_W-1:0]     data_word_1,
  input  wire logic [WORD_W-1:0]     data_word_2,
  input  wire logic [WORD_W-1:0]     data_word_3,
  input  wire logic [WORD_W-1:0]     data_word_4,
  input  wire logic [WORD_W-1:0]     data_word_5,
  input  wire logic [WORD_W-1:0]     data_word_6,
  input  wire logic [WORD_W-1:0]     data_word_7,
  input  wire logic                  result_valid,
  input  wire logic                  result_stall,
  input  wire logic                  accepted,
  input  wire logic [ID_W-1:0]       out_can_id,
  input  wire logic [TS_W-1:0]       out_timestamp,
  input  wire logic [DLEN_W-1:0]     out_length,
  input  wire logic [WORD_W-1:0]     out_data_word_0,
  input  wire logic [WORD_W-1:0]     out_data_word_1,
  input  wire logic [WORD_W-1:0]     out_data_word_2,
  input  wire logic [WORD_W-1:0]     out_data_word_3,
  input  wire logic [WORD_W-1:0]     out_data_word_4,
  input  wire logic [WORD_W-1:0]     out_data_word_5,
  input  wire logic [WORD_W-1:0]     out_data_word_6,
  input  wire logic [WORD_W-1:0]     out_data_word_7,
  output int                         errors,
  output int                         pending,
  output int                         new_frames,
  output int                         dup_frames,
  output int                         bad_frames
);

  localparam int CHANNELS       = CHANNELS_DEF;
  localparam int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF;
  localparam int OUT_DATA_BYTES = OUT_DATA_BYTES_DEF;

  typedef struct {
    logic              accepted;
    logic [ID_W-1:0]   can_id;
    logic [TS_W-1:0]   ts;
    logic [DLEN_W-1:0] dlen;
    logic [DATA_W-1:0] data;
  } delivery_t;

  // per-channel snapshot of the last delivered frame
  logic              snap_valid  [CHANNELS];
  logic [ID_W-1:0]   snap_id     [CHANNELS];
  logic [PARAMS_W-1:0] snap_params [CHANNELS];
  logic [TS_W-1:0]   snap_ts     [CHANNELS];
  int                snap_len    [CHANNELS];
  logic [DATA_W-1:0] snap_data   [CHANNELS];

  delivery_t pending_deliveries [$];
  int fail_total = 0;
  int n_new = 0;
  int n_dup = 0;
  int n_bad = 0;

  function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] d, input int len);
    logic [DATA_W-1:0] r;
    r = d;
    for (int i = 0; i < DATA_BYTES; i++)
      if (i >= len) r[8*i +: 8] = '0;
    return r;
  endfunction

  function automatic delivery_t predict_delivery(
    input logic [CH_FIELD_W-1:0] ch,
    input logic [ID_W-1:0]       id,
    input logic [PARAMS_W-1:0]   params,
    input logic [TS_W-1:0]       ts,
    input logic [DATA_W-1:0]     data
  );
    delivery_t d;
    logic [PARAMS_W-1:0] kept;
    logic [DATA_W-1:0] masked;
    int len;
    int olen;
    d.accepted = 1'b0;
    d.can_id   = '0;
    d.ts       = '0;
    d.dlen     = '0;
    d.data     = '0;
    if (int'(ch) >= CHANNELS) begin
      n_bad++;
      return d;
    end
    // bits 7:4 of the parameter word play no part
    kept = {params[15:8], 4'b0000, params[3:0]};
    len = int'(params[15:8]);
    if (len > MAX_DATA_BYTES) len = MAX_DATA_BYTES;
    masked = keep_bytes(data, len);
    if (snap_valid[ch] && snap_id[ch] == id && snap_params[ch] == kept &&
        snap_ts[ch] == ts && snap_len[ch] == len && snap_data[ch] == masked) begin
      n_dup++;
      return d;
    end
    olen = (len > OUT_DATA_BYTES) ? OUT_DATA_BYTES : len;
    d.accepted = 1'b1;
    d.can_id   = id;
    d.ts       = ts;
    d.dlen     = olen[DLEN_W-1:0];
    d.data     = keep_bytes(masked, olen);
    snap_valid[ch]  = 1'b1;
    snap_id[ch]     = id;
    snap_params[ch] = kept;
    snap_ts[ch]     = ts;
    snap_len[ch]    = len;
    snap_data[ch]   = masked;
    n_new++;
    return d;
  endfunction

  task automatic compare_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      fail_total++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    delivery_t exp_d;
    logic [DATA_W-1:0] act_data;
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) snap_valid[c] = 1'b0;
      pending_deliveries.delete();
    end else begin
      if (frame_valid && !frame_stall)
        pending_deliveries.push_back(predict_delivery(channel, can_id, frame_params, timestamp,
          {data_word_7, data_word_6, data_word_5, data_word_4,
           data_word_3, data_word_2, data_word_1, data_word_0}));
      if (result_valid && !result_stall) begin
        if (pending_deliveries.size() == 0) begin
          fail_total++;
          $display("%0t: result with no request outstanding: expected none, %s %b id %h",
                   $time, "actual accepted", accepted, out_can_id);
        end else begin
          exp_d = pending_deliveries.pop_front();
          act_data = {out_data_word_7, out_data_word_6, out_data_word_5, out_data_word_4,
                      out_data_word_3, out_data_word_2, out_data_word_1, out_data_word_0};
          compare_field("accepted", WORD_W'(exp_d.accepted), WORD_W'(accepted));
          compare_field("out_can_id", WORD_W'(exp_d.can_id), WORD_W'(out_can_id));
          compare_field("out_timestamp", WORD_W'(exp_d.ts), WORD_W'(out_timestamp));
          compare_field("out_length", WORD_W'(exp_d.dlen), WORD_W'(out_length));
          for (int k = 0; k < DATA_WORDS; k++)
            compare_field($sformatf("out_data_word_%0d", k), exp_d.data[k*WORD_W +: WORD_W],
                          act_data[k*WORD_W +: WORD_W]);
        end
      end
    end
    errors     <= fail_total;
    pending    <= pending_deliveries.size();
    new_frames <= n_new;
    dup_frames <= n_dup;
    bad_frames <= n_bad;
  end

endmodule

### sim/tb_can_rx_duplicate_frame_filter.sv
// Testbench top for the CAN receive duplicate-frame filter: frame stimulus and verdict.
// Depends on cdf_pkg, can_rx_duplicate_frame_filter and cdf_filter_checker.
module tb_can_rx_duplicate_frame_filter;
  import cdf_pkg::*;

  localparam int RANDOM_ITEMS  = 750;
  localparam int NO_IDLE_ITEMS = 150;
  localparam int HOLD_ITEMS    = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PCT      = 36;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CH_CODES      = 1 << CH_FIELD_W;

  typedef struct {
    logic [CH_FIELD_W-1:0] ch;
    logic [ID_W-1:0]       id;
    logic [PARAMS_W-1:0]   params;
    logic [TS_W-1:0]       ts;
    logic [DATA_W-1:0]     data;
  } can_frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic frame_valid = 1'b0;
  logic result_stall = 1'b0;
  logic [CH_FIELD_W-1:0] channel = '0;
  logic [ID_W-1:0]       can_id = '0;
  logic [PARAMS_W-1:0]   frame_params = '0;
  logic [TS_W-1:0]       timestamp = '0;
  logic [WORD_W-1:0] data_word_0 = '0, data_word_1 = '0, data_word_2 = '0, data_word_3 = '0;
  logic [WORD_W-1:0] data_word_4 = '0, data_word_5 = '0, data_word_6 = '0, data_word_7 = '0;

  logic              frame_stall;
  logic              result_valid;
  logic              accepted;
  logic [ID_W-1:0]   out_can_id;
  logic [TS_W-1:0]   out_timestamp;
  logic [DLEN_W-1:0] out_length;
  logic [WORD_W-1:0] out_data_word_0, out_data_word_1, out_data_word_2, out_data_word_3;
  logic [WORD_W-1:0] out_data_word_4, out_data_word_5, out_data_word_6, out_data_word_7;

  int errors, pending, new_frames, dup_frames, bad_frames;
  int cycle_count = 0;

  logic rx_idle_en = 1'b1;
  logic hold_trigger = 1'b0;
  bit   tx_idle_en = 1'b1;
  int   hold_left = 0;
  bit   hold_used = 1'b0;

  can_frame_t last_frame [CH_CODES];
  bit         have_last  [CH_CODES];

  can_rx_duplicate_frame_filter DUT (.*);
  cdf_filter_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random stalls, or one long counted hold-off once requested
  always @(posedge clk) begin
    if (hold_trigger && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (rx_idle_en) begin
      result_stall <= ($urandom_range(99) < IDLE_PCT);
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic logic [DATA_W-1:0] random_payload();
    logic [DATA_W-1:0] r;
    for (int i = 0; i < DATA_W / 32; i++) r[32*i +: 32] = $urandom;
    return r;
  endfunction

  function automatic can_frame_t make_frame(input logic [CH_FIELD_W-1:0] ch,
                                            input logic [ID_W-1:0] id,
                                            input logic [PARAMS_W-1:0] params,
                                            input logic [TS_W-1:0] ts,
                                            input logic [DATA_W-1:0] data);
    can_frame_t f;
    f.ch = ch;
    f.id = id;
    f.params = params;
    f.ts = ts;
    f.data = data;
    return f;
  endfunction

  function automatic int frame_len(input can_frame_t f);
    return (f.params[15:8] > MAX_DATA_BYTES_DEF) ? MAX_DATA_BYTES_DEF : int'(f.params[15:8]);
  endfunction

  // mostly repeats and near-repeats of the channel's last frame, the rest fresh frames
  function automatic can_frame_t random_frame();
    can_frame_t f;
    logic [CH_FIELD_W-1:0] ch;
    logic [DATA_W-1:0] noise;
    logic [7:0] raw;
    logic [7:0] flags;
    int pick;
    int len;
    int idx;
    ch = ($urandom_range(99) < 10) ? CH_FIELD_W'($urandom_range(CH_CODES - 1, CHANNELS_DEF))
                                   : CH_FIELD_W'($urandom_range(CHANNELS_DEF - 1, 0));
    pick = $urandom_range(99);
    if (have_last[ch] && pick < 35) begin
      f = last_frame[ch];
      if ($urandom_range(1)) begin
        // alter only what the filter must not see: bits 7:4 and bytes past the length
        f.params[7:4] = 4'($urandom_range(15));
        len = frame_len(f);
        noise = random_payload();
        for (int i = len; i < DATA_BYTES; i++) f.data[8*i +: 8] = noise[8*i +: 8];
      end
    end else if (have_last[ch] && pick < 65) begin
      f = last_frame[ch];
      len = frame_len(f);
      case ($urandom_range(5))
        0: f.id ^= ID_W'(1) << $urandom_range(ID_W - 1);
        1: f.ts ^= TS_W'(1) << $urandom_range(TS_W - 1);
        2: f.params ^= PARAMS_W'(1) << $urandom_range(3);
        3: f.params[15:8] = 8'($urandom_range(MAX_DATA_BYTES_DEF));
        4: begin
          if (len > 0) begin
            idx = int'($urandom_range(len - 1));
            f.data[8*idx +: 8] ^= 8'($urandom_range(255, 1));
          end else begin
            f.id ^= ID_W'(1);
          end
        end
        default: f.params[15:8] = 8'($urandom_range(255, MAX_DATA_BYTES_DEF + 1));
      endcase
    end else begin
      pick = $urandom_range(99);
      if (pick < 60)      raw = 8'($urandom_range(MAX_DATA_BYTES_DEF));
      else if (pick < 80) raw = 8'($urandom_range(8));
      else                raw = 8'($urandom_range(255, MAX_DATA_BYTES_DEF + 1));
      flags = 8'($urandom_range(255));
      f = make_frame(ch, $urandom, {raw, flags}, $urandom, random_payload());
    end
    return f;
  endfunction

  task automatic send_frame(input can_frame_t f);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid  <= 1'b1;
    channel      <= f.ch;
    can_id       <= f.id;
    frame_params <= f.params;
    timestamp    <= f.ts;
    data_word_0  <= f.data[0*WORD_W +: WORD_W];
    data_word_1  <= f.data[1*WORD_W +: WORD_W];
    data_word_2  <= f.data[2*WORD_W +: WORD_W];
    data_word_3  <= f.data[3*WORD_W +: WORD_W];
    data_word_4  <= f.data[4*WORD_W +: WORD_W];
    data_word_5  <= f.data[5*WORD_W +: WORD_W];
    data_word_6  <= f.data[6*WORD_W +: WORD_W];
    data_word_7  <= f.data[7*WORD_W +: WORD_W];
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    last_frame[f.ch] = f;
    have_last[f.ch]  = 1'b1;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    can_frame_t f;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty frame on a fresh channel, then repeats the filter must treat as the same
    f = make_frame(CH_FIELD_W'(0), '0, '0, '0, '0);
    send_frame(f);
    send_frame(f);
    f.params[7:4] = 4'hF;
    send_frame(f);
    f.data = '1;
    send_frame(f);

    // all-ones frame at full length, then long raw lengths that clamp
    f = make_frame(CH_FIELD_W'(1), '1, {8'd64, 8'hFF}, '1, '1);
    send_frame(f);
    send_frame(f);
    f.params[15:8] = 8'd255;
    send_frame(f);
    send_frame(f);
    f.params[15:8] = 8'd65;
    send_frame(f);

    // channels past the last one
    f.ch = 3'd4;
    send_frame(f);
    f.ch = 3'd7;
    send_frame(f);
    send_frame(make_frame(CH_FIELD_W'(5), '0, '0, '0, '0));

    // short frame: bytes past the length ignored, inside it compared
    f = make_frame(CH_FIELD_W'(2), 32'h0000_0123, {8'd3, 8'h00}, 32'h1000_0000,
                   random_payload());
    send_frame(f);
    f.data[24 +: 8] ^= 8'hFF;
    send_frame(f);
    f.data[16 +: 8] ^= 8'hFF;
    send_frame(f);
    f.ts = f.ts + 32'd1;
    send_frame(f);
    f.id ^= 32'h1;
    send_frame(f);

    // each flag toggled in turn, then a byte inside the length and one past it
    f = make_frame(CH_FIELD_W'(3), $urandom, {8'd8, 8'h00}, $urandom, random_payload());
    send_frame(f);
    f.params ^= 16'h0001;
    send_frame(f);
    f.params ^= 16'h0002;
    send_frame(f);
    f.params ^= 16'h0004;
    send_frame(f);
    f.params ^= 16'h0008;
    send_frame(f);
    f.data[56 +: 8] ^= 8'h5A;
    send_frame(f);
    f.data[64 +: 8] ^= 8'h5A;
    send_frame(f);
    // same frame on another channel is new there
    f.ch = 3'd0;
    send_frame(f);

    // random: a stretch with no idling, then the hold-off, then idling on both sides
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    repeat (NO_IDLE_ITEMS) send_frame(random_frame());
    hold_trigger <= 1'b1;
    repeat (HOLD_ITEMS) send_frame(random_frame());
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    repeat (RANDOM_ITEMS - NO_IDLE_ITEMS - HOLD_ITEMS) send_frame(random_frame());
    frame_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d frames: %0d delivered, %0d repeats dropped, %0d on bad channels",
             new_frames + dup_frames + bad_frames, new_frames, dup_frames, bad_frames);
    $display("Included a %0d-cycle result hold-off with input backpressure; %0d cycles run",
             HOLD_CYCLES, cycle_count);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/cdf_pkg.sv
rtl/cdf_ram.sv
rtl/cdf_frame_cmp.sv
rtl/can_rx_duplicate_frame_filter.sv
sim/cdf_filter_checker.sv
sim/tb_can_rx_duplicate_frame_filter.sv
